// File: sv/cgsl_pkg.sv
// Shared constants and types for the cascaded golden slew limiter.
package cgsl_pkg;

   // Default geometry of the limiter cascade.
   localparam int STAGE_COUNT_DEF = 10;
   localparam int SAMPLE_BITS_DEF = 24;

   // Width of the base step register.
   localparam int BASE_BITS = 24;

   // Register port geometry.
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // Register index, taken from the word address bit.
   localparam logic REG_BASE_STEP = 1'b0;

   // Golden ratio in unsigned Q32 is 2^32 plus this fraction.
   localparam logic [31:0] PHI_FRAC   = 32'd2654435769;
   localparam logic [31:0] ROUND_HALF = 32'h8000_0000;

   // Per-cycle commands from the sequencer to both channel lanes.
   typedef struct packed {
      logic load;
      logic step;
   } lane_ctrl_type;

endpackage

// File: sv/cgsl_limit_gen.sv
// Derives and holds the per-stage slew limits from the base step.
module cgsl_limit_gen #(
   parameter int STAGE_COUNT = cgsl_pkg::STAGE_COUNT_DEF,
   parameter int SAMPLE_BITS = cgsl_pkg::SAMPLE_BITS_DEF,
   localparam int STG_W = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           base_wr,
   input  logic [cgsl_pkg::BASE_BITS-1:0] base_wdata,
   input  logic [STG_W-1:0]               stage_sel,
   output logic [cgsl_pkg::BASE_BITS-1:0] base_step,
   output logic [SAMPLE_BITS:0]           limit,
   output logic                           busy
);

   localparam int LW     = SAMPLE_BITS + 1;
   localparam int CMP_W  = (LW > cgsl_pkg::BASE_BITS) ? LW : cgsl_pkg::BASE_BITS + 1;
   localparam int PROD_W = LW + 32;
   localparam logic [CMP_W-1:0] FULL_C   = CMP_W'(1) << SAMPLE_BITS;
   localparam logic [LW:0]      FULL_SUM = (LW + 1)'(1) << SAMPLE_BITS;

   typedef enum logic [2:0] {
      GEN_IDLE = 3'b001,
      GEN_MUL  = 3'b010,
      GEN_ADD  = 3'b100
   } gen_state_type;

   gen_state_type            state_ff, state_in;
   logic [cgsl_pkg::BASE_BITS-1:0] base_ff, base_in;
   logic [LW-1:0]            lim_ff, lim_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic [STG_W-1:0]         idx_ff, idx_in;
   logic [LW-1:0]            limit_ff [STAGE_COUNT];

   logic [CMP_W-1:0]         wdata_ext;
   logic [LW-1:0]            lim_init;
   logic [PROD_W-1:0]        prod_round;
   logic [LW-1:0]            prod_hi;
   logic [LW:0]              lim_sum;
   logic [LW-1:0]            lim_next;

   // Start value: the written base, saturated at full scale.
   assign wdata_ext = CMP_W'(base_wdata);
   assign lim_init  = (wdata_ext > FULL_C) ? LW'(FULL_C) : LW'(wdata_ext);

   // Times phi is the value itself plus the rounded fractional product.
   assign prod_round = prod_ff + PROD_W'(cgsl_pkg::ROUND_HALF);
   assign prod_hi    = prod_round[PROD_W-1:32];
   assign lim_sum    = {1'b0, lim_ff} + {1'b0, prod_hi};
   assign lim_next   = (lim_sum > FULL_SUM) ? LW'(FULL_SUM) : lim_sum[LW-1:0];

   // Sequencer: walk from the last stage to the first, a multiply and an add between stages.
   always_comb begin
      state_in = state_ff;
      base_in  = base_ff;
      lim_in   = lim_ff;
      prod_in  = prod_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         GEN_IDLE: begin
         end
         GEN_MUL: begin
            prod_in = PROD_W'(lim_ff) * PROD_W'(cgsl_pkg::PHI_FRAC);
            if (idx_ff == '0) begin
               state_in = GEN_IDLE;
            end else begin
               state_in = GEN_ADD;
            end
         end
         GEN_ADD: begin
            lim_in   = lim_next;
            idx_in   = idx_ff - STG_W'(1);
            state_in = GEN_MUL;
         end
         default: begin
            state_in = GEN_IDLE;
         end
      endcase
      if (base_wr) begin
         base_in  = base_wdata;
         lim_in   = lim_init;
         idx_in   = STG_W'(STAGE_COUNT - 1);
         state_in = GEN_MUL;
      end
   end

   // Control state and the limit table clear on reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= GEN_IDLE;
         base_ff  <= '0;
         for (int i = 0; i < STAGE_COUNT; i++) begin
            limit_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         base_ff  <= base_in;
         if (state_ff == GEN_MUL) begin
            limit_ff[idx_ff] <= lim_ff;
         end
      end
   end

   // Working values of the derivation.
   always_ff @(posedge clock) begin
      lim_ff  <= lim_in;
      prod_ff <= prod_in;
      idx_ff  <= idx_in;
   end

   assign base_step = base_ff;
   assign limit     = limit_ff[stage_sel];
   assign busy      = (state_ff != GEN_IDLE);

endmodule

// File: sv/cgsl_lane.sv
// One channel lane: a shared slew clamp stepped over the stage memories.
module cgsl_lane #(
   parameter int STAGE_COUNT = cgsl_pkg::STAGE_COUNT_DEF,
   parameter int SAMPLE_BITS = cgsl_pkg::SAMPLE_BITS_DEF,
   localparam int STG_W = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cgsl_pkg::lane_ctrl_type       ctrl,
   input  logic [STG_W-1:0]              stage_sel,
   input  logic [SAMPLE_BITS:0]          limit,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   output logic signed [SAMPLE_BITS-1:0] result
);

   localparam int EW = SAMPLE_BITS + 2;

   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   logic signed [SAMPLE_BITS-1:0] mem_ff [STAGE_COUNT];

   logic signed [SAMPLE_BITS-1:0] m_cur;
   logic signed [EW-1:0]          x_ext, m_ext, lim_ext;
   logic signed [EW-1:0]          diff_up, diff_dn, sum_up, sum_dn;

   // Widen everything so differences and limits compare without overflow.
   assign m_cur   = mem_ff[stage_sel];
   assign x_ext   = {{2{x_ff[SAMPLE_BITS-1]}}, x_ff};
   assign m_ext   = {{2{m_cur[SAMPLE_BITS-1]}}, m_cur};
   assign lim_ext = {1'b0, limit};
   assign diff_up = x_ext - m_ext;
   assign diff_dn = m_ext - x_ext;
   assign sum_up  = m_ext + lim_ext;
   assign sum_dn  = m_ext - lim_ext;

   // Load a new sample, or clamp the step from this stage's previous output to its limit.
   always_comb begin
      x_in = x_ff;
      if (ctrl.load) begin
         x_in = sample;
      end else if (ctrl.step) begin
         if (diff_up > lim_ext) begin
            x_in = sum_up[SAMPLE_BITS-1:0];
         end else if (diff_dn > lim_ext) begin
            x_in = sum_dn[SAMPLE_BITS-1:0];
         end
      end
   end

   // Stage memories reset to zero; each step updates the selected stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STAGE_COUNT; i++) begin
            mem_ff[i] <= '0;
         end
      end else if (ctrl.step) begin
         mem_ff[stage_sel] <= x_in;
      end
   end

   // Running sample through the cascade.
   always_ff @(posedge clock) begin
      x_ff <= x_in;
   end

   assign result = x_ff;

endmodule

// File: sv/cascaded_golden_slew_limiter.sv
// Top level: register port, stage sequencer, two channel lanes and the output merge.
// An accepted beat loads both lanes, steps through every stage, then waits to be registered at the output.
// No new beat is taken before that; each lane runs its one clamp unit once per stage.
// A base step write runs the limit derivation; input waits meanwhile.
// Reset (synchronous) clears base step, all stage limits and all stage memories to zero.
module cascaded_golden_slew_limiter #(
   parameter int STAGE_COUNT = cgsl_pkg::STAGE_COUNT_DEF,
   parameter int SAMPLE_BITS = cgsl_pkg::SAMPLE_BITS_DEF,
   localparam int DATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // Fields from bit 0: left_sample, right_sample, zero padding.
   input  logic [DATA_W-1:0]                  req_tdata,
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // Fields from bit 0: left_result, right_result, zero padding.
   output logic [DATA_W-1:0]                  rsp_tdata,
   output logic                               rsp_tlast,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [cgsl_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [cgsl_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [cgsl_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);

   localparam int STG_W = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_HOLD = 3'b100
   } seq_state_type;

   seq_state_type state_ff, state_in;
   logic [STG_W-1:0] stage_ff, stage_in;
   logic             frame_ff, frame_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] left_out_ff, left_out_in;
   logic signed [SAMPLE_BITS-1:0] right_out_ff, right_out_in;
   logic             last_out_ff, last_out_in;

   logic                           csr_write, base_wr;
   logic [cgsl_pkg::BASE_BITS-1:0] base_step;
   logic [SAMPLE_BITS:0]           limit;
   logic                           gen_busy;
   logic                           req_accept, out_free;
   cgsl_pkg::lane_ctrl_type        lane_ctrl;
   logic signed [SAMPLE_BITS-1:0]  left_in, right_in, left_res, right_res;

   // Register port: writes complete in the access phase, reads return the base step at its address and zero elsewhere.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign base_wr    = csr_write && (csr_paddr[2] == cgsl_pkg::REG_BASE_STEP);

   always_comb begin
      unique case (csr_paddr[2])
         cgsl_pkg::REG_BASE_STEP: csr_prdata = cgsl_pkg::CSR_DATA_BITS'(base_step);
         default:                 csr_prdata = '0;
      endcase
   end

   // Limit table shared by both lanes.
   cgsl_limit_gen #(
      .STAGE_COUNT (STAGE_COUNT),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_limit_gen (
      .clock      (clock),
      .reset      (reset),
      .base_wr    (base_wr),
      .base_wdata (csr_pwdata[cgsl_pkg::BASE_BITS-1:0]),
      .stage_sel  (stage_ff),
      .base_step  (base_step),
      .limit      (limit),
      .busy       (gen_busy)
   );

   // Input beat handshake.
   assign req_tready = (state_ff == ST_IDLE) && !gen_busy && !base_wr;
   assign req_accept = req_tvalid & req_tready;
   assign left_in    = req_tdata[SAMPLE_BITS-1:0];
   assign right_in   = req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

   assign lane_ctrl.load = req_accept;
   assign lane_ctrl.step = (state_ff == ST_RUN);

   // One lane per channel.
   cgsl_lane #(
      .STAGE_COUNT (STAGE_COUNT),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_lane_left (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (lane_ctrl),
      .stage_sel (stage_ff),
      .limit     (limit),
      .sample    (left_in),
      .result    (left_res)
   );

   cgsl_lane #(
      .STAGE_COUNT (STAGE_COUNT),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_lane_right (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (lane_ctrl),
      .stage_sel (stage_ff),
      .limit     (limit),
      .sample    (right_in),
      .result    (right_res)
   );

   // Sequencer and output merge: step the stages, then hand both lanes to the output register.
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      stage_in     = stage_ff;
      frame_in     = frame_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      left_out_in  = left_out_ff;
      right_out_in = right_out_ff;
      last_out_in  = last_out_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               stage_in = '0;
               frame_in = req_tlast;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (stage_ff == STG_W'(STAGE_COUNT - 1)) begin
               state_in = ST_HOLD;
            end else begin
               stage_in = stage_ff + STG_W'(1);
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               left_out_in  = left_res;
               right_out_in = right_res;
               last_out_in  = frame_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         stage_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stage_ff     <= stage_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff     <= frame_in;
      left_out_ff  <= left_out_in;
      right_out_ff <= right_out_in;
      last_out_ff  <= last_out_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'({right_out_ff, left_out_ff});
   assign rsp_tlast  = last_out_ff;

   // An accepted beat always starts the cascade at the first stage.
   a_accept_starts_run: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_RUN) && (stage_ff == '0))
      else $error("accepted beat did not start at the first stage");

   // The stage counter never leaves the cascade.
   a_stage_in_range: assert property (@(posedge clock) disable iff (reset)
      stage_ff <= STG_W'(STAGE_COUNT - 1))
      else $error("stage counter out of range");

   // A base step write always starts a limit derivation.
   a_write_derives: assert property (@(posedge clock) disable iff (reset)
      base_wr |=> gen_busy)
      else $error("base step write did not start limit derivation");

   // No beat enters while limits are being derived.
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      gen_busy |-> !req_accept)
      else $error("beat accepted during limit derivation");

   // New results come only out of the hold state.
   a_result_from_hold: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_HOLD))
      else $error("result raised outside the hold state");

endmodule

// File: tb/tb.sv
// Self-checking bench for the cascaded golden slew limiter: stereo streams under gaps and stalls.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STAGES = cgsl_pkg::STAGE_COUNT_DEF;
   localparam int SBITS = cgsl_pkg::SAMPLE_BITS_DEF;
   localparam int CSR_ADDR_BITS = cgsl_pkg::CSR_ADDR_BITS;
   localparam int CSR_DATA_BITS = cgsl_pkg::CSR_DATA_BITS;
   localparam int BASE_BITS = cgsl_pkg::BASE_BITS;
   localparam int DATA_W = ((2 * SBITS + 7) / 8) * 8;
   localparam longint FULL_SCALE = longint'(1) << SBITS;
   localparam longint SMAX = (longint'(1) << (SBITS - 1)) - 1;
   localparam longint SMIN = -(longint'(1) << (SBITS - 1));
   localparam logic [63:0] PHI_Q32 = (64'd1 << 32) + 64'(cgsl_pkg::PHI_FRAC);
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_BASE_STEP = {cgsl_pkg::REG_BASE_STEP, 2'b00};
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_SPARE = {~cgsl_pkg::REG_BASE_STEP, 2'b00};

   typedef struct {
      logic [SBITS-1:0] left;
      logic [SBITS-1:0] right;
      logic             last;
   } stereo_beat_type;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   // Fields from bit 0: left_sample, right_sample, zero padding.
   logic [DATA_W-1:0]        req_tdata = '0;
   logic                     req_tlast = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // Fields from bit 0: left_result, right_result, zero padding.
   logic [DATA_W-1:0]        rsp_tdata;
   logic                     rsp_tlast;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   cascaded_golden_slew_limiter uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Bench copy of the limiter state and its configuration.
   longint unsigned base_step_q = 0;
   longint unsigned limit_q[STAGES];
   longint          stage_mem[2][STAGES];

   stereo_beat_type sample_backlog[$];
   stereo_beat_type pending_outputs[$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int errors = 0;
   int beats_queued = 0;
   int beats_sent = 0;
   int results_seen = 0;
   int settings_used = 0;
   longint walk_left = 0;
   longint walk_right = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the result stream stalls for good.
   initial begin
      #20ms;
      $display("Regression FAIL");
      $finish;
   end

   function automatic void note_error(string msg);
      errors++;
      if (errors <= 10) begin
         $display("ERROR: %s", msg);
      end
   endfunction

   // Stage limits: base step at the last stage, scaled by phi toward the first, saturated.
   function automatic void derive_stage_limits();
      longint unsigned lim;
      int k;
      lim = base_step_q;
      if (lim > FULL_SCALE) lim = FULL_SCALE;
      for (k = STAGES - 1; k >= 0; k--) begin
         limit_q[k] = lim;
         lim = (lim * PHI_Q32 + 64'(cgsl_pkg::ROUND_HALF)) >> 32;
         if (lim > FULL_SCALE) lim = FULL_SCALE;
      end
   endfunction

   // Runs one channel sample through every stage clamp and updates that channel's memories.
   function automatic longint slew_cascade(int chan, longint x);
      longint y;
      longint m;
      longint lim;
      int k;
      y = x;
      for (k = 0; k < STAGES; k++) begin
         lim = longint'(limit_q[k]);
         m = stage_mem[chan][k];
         if (y - m > lim) begin
            y = m + lim;
         end else if (m - y > lim) begin
            y = m - lim;
         end
         stage_mem[chan][k] = y;
      end
      return y;
   endfunction

   function automatic void predict_beat(logic [SBITS-1:0] left, logic [SBITS-1:0] right,
                                        logic last);
      stereo_beat_type res;
      res.left = SBITS'(slew_cascade(0, longint'($signed(left))));
      res.right = SBITS'(slew_cascade(1, longint'($signed(right))));
      res.last = last;
      pending_outputs.push_back(res);
   endfunction

   function automatic void check_field(string name, logic [SBITS-1:0] want,
                                       logic [SBITS-1:0] got);
      if (want !== got) begin
         note_error($sformatf("result %0d %s: expected %0d, got %0d", results_seen, name,
                              $signed(want), $signed(got)));
      end
   endfunction

   // Sender: offers the next queued beat, predicts each beat the block accepts.
   always @(posedge clock) begin : drive_req
      stereo_beat_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_beat(req_tdata[SBITS-1:0], req_tdata[2*SBITS-1:SBITS], req_tlast);
            beats_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (sample_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               nxt = sample_backlog.pop_front();
               req_tdata <= DATA_W'({nxt.right, nxt.left});
               req_tlast <= nxt.last;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random back-pressure, each beat checked against the oldest prediction.
   always @(posedge clock) begin : watch_rsp
      stereo_beat_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (pending_outputs.size() == 0) begin
               note_error($sformatf("result %0d arrived with nothing expected", results_seen));
            end else begin
               want = pending_outputs.pop_front();
               check_field("left", want.left, rsp_tdata[SBITS-1:0]);
               check_field("right", want.right, rsp_tdata[2*SBITS-1:SBITS]);
               check_field("frame end", SBITS'(want.last), SBITS'(rsp_tlast));
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   function automatic void push_beat(longint left, longint right, logic last);
      stereo_beat_type b;
      b.left = SBITS'(left);
      b.right = SBITS'(right);
      b.last = last;
      sample_backlog.push_back(b);
      beats_queued++;
   endfunction

   // Mostly bounded steps from the previous sample, with full-range jumps and extremes.
   function automatic longint pick_sample(longint prev);
      int pick;
      int span;
      longint step;
      pick = $urandom_range(0, 99);
      if (pick < 25) return longint'($signed(SBITS'($urandom)));
      if (pick < 35) begin
         case ($urandom_range(0, 3))
            0: return SMAX;
            1: return SMIN;
            2: return 0;
            default: return -1;
         endcase
      end
      span = $urandom_range(0, SBITS);
      step = longint'($urandom) & ((longint'(1) << span) - 1);
      if ($urandom_range(0, 1) == 1) step = -step;
      step += prev;
      if (step > SMAX) step = SMAX;
      if (step < SMIN) step = SMIN;
      return step;
   endfunction

   task automatic queue_random_beats(int count);
      int n;
      for (n = 0; n < count; n++) begin
         walk_left = pick_sample(walk_left);
         walk_right = ($urandom_range(0, 9) == 0) ? walk_left : pick_sample(walk_right);
         push_beat(walk_left, walk_right, $urandom_range(0, 7) == 0);
      end
   endtask

   // Waits until every queued beat went in and every predicted result came out.
   task automatic drain_pipeline();
      while (results_seen < beats_queued) begin
         @(posedge clock);
      end
      repeat (STAGES + 4) @(posedge clock);
   endtask

   // Register write: setup cycle, then access cycle; the write lands at the access edge.
   task automatic csr_write(logic [CSR_ADDR_BITS-1:0] addr, logic [CSR_DATA_BITS-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr[CSR_ADDR_BITS-1] == cgsl_pkg::REG_BASE_STEP) begin
         base_step_q = data[BASE_BITS-1:0];
         derive_stage_limits();
         settings_used++;
      end
      @(posedge clock);
   endtask

   // Register read: the data is taken at the access edge and compared with the bench copy.
   task automatic csr_read_check(logic [CSR_ADDR_BITS-1:0] addr);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== CSR_DATA_BITS'(base_step_q)) begin
         note_error($sformatf("base step readback: expected %0h, got %0h",
                              CSR_DATA_BITS'(base_step_q), csr_prdata));
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : run_regression
      int phase;
      logic [CSR_DATA_BITS-1:0] base;
      derive_stage_limits();
      foreach (stage_mem[c, k]) stage_mem[c][k] = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Out of reset every limit is zero, so the output holds at zero.
      push_beat(SMAX, SMIN, 1'b0);
      push_beat(SMIN, SMAX, 1'b1);
      push_beat(-1, 1, 1'b0);
      drain_pipeline();

      // A write to the spare address is dropped; upper data bits of the base step are dropped.
      csr_write(ADDR_SPARE, 32'hFFFF_FFFF);
      csr_read_check(ADDR_BASE_STEP);
      csr_write(ADDR_BASE_STEP, 32'hFF80_0000);
      csr_read_check(ADDR_BASE_STEP);
      push_beat(SMAX, SMIN, 1'b0);
      push_beat(SMIN, SMAX, 1'b1);
      push_beat(SMAX, SMAX, 1'b0);
      push_beat(SMIN, SMIN, 1'b0);
      push_beat(0, -1, 1'b1);
      push_beat(-1, 0, 1'b0);
      push_beat(SMAX, SMIN, 1'b0);
      push_beat(1, -2, 1'b1);
      drain_pipeline();

      // Largest base step: every derived stage but the last, which holds the base step, saturates at full scale.
      csr_write(ADDR_BASE_STEP, 32'h00FF_FFFF);
      csr_read_check(ADDR_BASE_STEP);
      push_beat(SMIN, SMAX, 1'b0);
      push_beat(SMAX, SMIN, 1'b1);
      push_beat(SMIN, SMAX, 1'b0);
      drain_pipeline();

      // Smallest nonzero step: full-scale jumps are clamped hard.
      csr_write(ADDR_BASE_STEP, 32'h0000_0001);
      push_beat(SMAX, SMIN, 1'b0);
      push_beat(SMAX, SMIN, 1'b0);
      push_beat(SMIN, SMAX, 1'b1);
      push_beat(0, 0, 1'b0);
      drain_pipeline();

      // Random phases: each idling mode under two base step settings.
      for (phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
            default: begin send_idle_pct = 26; recv_stall_pct = 26; end
         endcase
         case (phase)
            0: base = 32'd1;
            1: base = 32'h0080_0000;
            2: base = 32'h00FF_FFFF;
            3: base = 32'd0;
            4: base = $urandom_range(2, 4096);
            5: base = $urandom;
            6: base = $urandom_range(100, 300);
            default: base = $urandom & 32'h003F_FFFF;
         endcase
         csr_write(ADDR_BASE_STEP, base);
         csr_read_check(ADDR_BASE_STEP);
         if (phase == 2) begin
            // The sender holds off halfway until the block has handed back everything.
            queue_random_beats(112);
            drain_pipeline();
            queue_random_beats(113);
         end else begin
            queue_random_beats(225);
         end
         drain_pipeline();
      end

      if (pending_outputs.size() != 0) begin
         note_error($sformatf("%0d results never arrived", pending_outputs.size()));
      end
      $display("Covered %0d stereo beats and %0d results across %0d base step settings,",
               beats_sent, results_seen, settings_used);
      $display("with sender gaps, result back-pressure and a full drain mid-stream.");
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Mismatches: %0d", errors);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/cgsl_pkg.sv
sv/cgsl_limit_gen.sv
sv/cgsl_lane.sv
sv/cascaded_golden_slew_limiter.sv
tb/tb.sv
